FILE: sv/lpe_pkg.sv
package lpe_pkg;

    localparam int DATA_W = 32;
    localparam int DEG_W  = 6;
    localparam int PROD_W = 64;
    localparam int TERM_W = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] point;
        logic [DEG_W-1:0]         degree;
    } t_lpe_job;

    typedef struct packed {
        logic signed [DATA_W-1:0] prior_poly_value;
        logic signed [DATA_W-1:0] poly_value;
    } t_lpe_res;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lpe_stat;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_XC   = 9'b000000010,
        S_PV   = 9'b000000100,
        S_MM   = 9'b000001000,
        S_T    = 9'b000010000,
        S_LO   = 9'b000100000,
        S_HI   = 9'b001000000,
        S_Q    = 9'b010000000,
        S_DONE = 9'b100000000
    } t_lpe_state;

endpackage

FILE: sv/lpe_mul.sv
module lpe_mul import lpe_pkg::*; (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: sv/lpe_rrom.sv
module lpe_rrom import lpe_pkg::*; (
    input  logic [DEG_W-1:0]  i_k,
    output logic [DATA_W-1:0] o_r
);

    localparam int DEPTH = 2 ** DEG_W;

    logic [DATA_W-1:0] w_rom [0:DEPTH-1];

    // Rounded reciprocal of k scaled by 2^32; entries below two are unused.
    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic [63:0] RV = (g < 2) ? 64'd0 :
                                     ((64'd1 << 32) + 64'(g / 2)) / 64'(g);
        assign w_rom[g] = RV[DATA_W-1:0];
    end

    assign o_r = w_rom[i_k];

endmodule

FILE: sv/lpe_core.sv
module lpe_core import lpe_pkg::*; #(
    parameter int MAX_DEGREE = 50,
    parameter int FRAC_BITS  = 30
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_lpe_job  i_job,
    input  logic      i_take,
    output t_lpe_stat o_stat,
    output t_lpe_res  o_res
);

    localparam logic [DATA_W-1:0] ONE      = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [PROD_W-1:0] HALF_32  = PROD_W'(64'd1 << 31);
    localparam logic [DEG_W-1:0]  N_MAX    = DEG_W'(MAX_DEGREE);
    localparam logic [TERM_W:0]   LIM_NEG  = (TERM_W+1)'(64'd1 << 31);
    localparam logic [TERM_W:0]   LIM_POS  = (TERM_W+1)'((64'd1 << 31) - 64'd1);

    t_lpe_state r_state, n_state;

    logic [DATA_W-1:0] r_xmag, r_cmag, r_pmag, r_mmag, r_recip, r_lor;
    logic              r_xsgn, r_csgn, r_psgn, r_tsgn;
    logic [DEG_W-1:0]  r_k, r_n;
    logic [37:0]       r_p2;
    logic [TERM_W-1:0] r_tmag;

    logic [DATA_W-1:0] w_mul_a, w_mul_b, w_recip, w_x_mag, w_m, w_lor, w_qsat;
    logic [PROD_W-1:0] w_prod, w_rnd, w_lor_sum;
    logic [DATA_W:0]   w_in_mag;
    logic [DEG_W-1:0]  w_n, w_km1;
    logic [DEG_W:0]    w_k2m1;
    logic [TERM_W-1:0] w_p1, w_sum, w_d, w_dn, w_tmag;
    logic              w_s1, w_s2, w_tsgn;
    logic [TERM_W:0]   w_q, w_lim;

    lpe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    lpe_rrom u_rrom (
        .i_k (r_k),
        .o_r (w_recip)
    );

    always_comb begin
        w_in_mag = i_job.point[DATA_W-1] ? ((DATA_W+1)'(0) - {i_job.point[DATA_W-1], i_job.point})
                                         : {1'b0, i_job.point};
        w_x_mag  = (w_in_mag > {1'b0, ONE}) ? ONE : w_in_mag[DATA_W-1:0];
        w_n      = (i_job.degree > N_MAX) ? N_MAX : i_job.degree;
    end

    assign w_km1  = r_k - DEG_W'(1);
    assign w_k2m1 = {r_k, 1'b0} - (DEG_W+1)'(1);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_XC: begin
                w_mul_a = r_xmag;
                w_mul_b = r_cmag;
            end
            S_PV: begin
                w_mul_a = DATA_W'(w_km1);
                w_mul_b = r_pmag;
            end
            S_MM: begin
                w_mul_a = DATA_W'(w_k2m1);
                w_mul_b = r_mmag;
            end
            S_LO: begin
                w_mul_a = r_tmag[DATA_W-1:0];
                w_mul_b = r_recip;
            end
            S_HI: begin
                w_mul_a = DATA_W'(r_tmag[TERM_W-1:DATA_W]);
                w_mul_b = r_recip;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_rnd = w_prod + HALF_LSB;
    assign w_m   = DATA_W'(w_rnd >> FRAC_BITS);

    // The two recurrence terms are combined in sign-magnitude form.
    always_comb begin
        w_p1  = TERM_W'(w_prod[38:0]);
        w_s1  = r_xsgn ^ r_csgn;
        w_s2  = ~r_psgn;
        w_sum = w_p1 + TERM_W'(r_p2);
        w_d   = w_p1 - TERM_W'(r_p2);
        w_dn  = TERM_W'(r_p2) - w_p1;
        if (w_s1 == w_s2) begin
            w_tmag = w_sum;
            w_tsgn = w_s1;
        end else if (w_d[TERM_W-1]) begin
            w_tmag = w_dn;
            w_tsgn = w_s2;
        end else begin
            w_tmag = w_d;
            w_tsgn = w_s1;
        end
    end

    assign w_lor_sum = w_prod + HALF_32;
    assign w_lor     = w_lor_sum[PROD_W-1:DATA_W];

    always_comb begin
        w_q    = (TERM_W+1)'(w_prod[TERM_W-1:0]) + (TERM_W+1)'(r_lor);
        w_lim  = r_tsgn ? LIM_NEG : LIM_POS;
        w_qsat = (w_q > w_lim) ? w_lim[DATA_W-1:0] : w_q[DATA_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (w_n < DEG_W'(2)) ? S_DONE : S_XC;
                end
            end
            S_XC:   n_state = S_PV;
            S_PV:   n_state = S_MM;
            S_MM:   n_state = S_T;
            S_T:    n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_Q;
            S_Q:    n_state = (r_k == r_n) ? S_DONE : S_XC;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_xmag <= w_x_mag;
                    r_xsgn <= i_job.point[DATA_W-1];
                    r_n    <= w_n;
                    r_k    <= DEG_W'(2);
                    if (w_n == DEG_W'(0)) begin
                        r_cmag <= ONE;
                        r_csgn <= 1'b0;
                        r_pmag <= '0;
                        r_psgn <= 1'b0;
                    end else begin
                        r_cmag <= w_x_mag;
                        r_csgn <= i_job.point[DATA_W-1];
                        r_pmag <= ONE;
                        r_psgn <= 1'b0;
                    end
                end
            end
            S_XC: r_recip <= w_recip;
            S_PV: r_mmag  <= w_m;
            S_MM: r_p2    <= w_prod[37:0];
            S_T: begin
                r_tmag <= w_tmag;
                r_tsgn <= w_tsgn;
            end
            S_HI: r_lor <= w_lor;
            S_Q: begin
                r_pmag <= r_cmag;
                r_psgn <= r_csgn;
                r_cmag <= w_qsat;
                r_csgn <= r_tsgn;
                if (r_k != r_n) begin
                    r_k <= r_k + DEG_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    assign o_res.poly_value       = $signed(r_csgn ? (DATA_W'(0) - r_cmag) : r_cmag);
    assign o_res.prior_poly_value = $signed(r_psgn ? (DATA_W'(0) - r_pmag) : r_pmag);

endmodule

FILE: sv/legendre_polynomial_eval.sv
// An accepted word runs one recurrence step for each k from two up to its degree n,
// through states XC, PV, MM, T, LO, HI and Q on the single shared 32x32 multiplier;
// degree zero or one goes straight to done. One word is taken at a time: the next
// is accepted only once the previous result is in the output register, which waits
// while the output word is stalled.
// Reset is synchronous and active low; it sets the degree to one and empties the output.
module legendre_polynomial_eval import lpe_pkg::*; #(
    parameter int MAX_DEGREE = 50,
    parameter int FRAC_BITS  = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // point
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [2*DATA_W-1:0] o_m_axis_tdata, // prior_poly_value high, poly_value low
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DEG_W-1:0]  i_cfg_data        // degree
);

    logic [DEG_W-1:0] r_degree;
    logic             r_ovalid;
    t_lpe_res         r_odata;

    t_lpe_job  w_job;
    t_lpe_res  w_res;
    t_lpe_stat w_stat;
    logic      w_start, w_take;

    assign w_job.point  = $signed(i_s_axis_tdata);
    assign w_job.degree = r_degree;
    assign w_start      = i_s_axis_tvalid & w_stat.idle;
    assign w_take       = w_stat.done & (~r_ovalid | i_m_axis_tready);

    lpe_core #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_job   (w_job),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEG_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_degree <= i_cfg_data;
            end
            if (w_take) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_odata <= w_res;
        end
    end

    assign o_s_axis_tready = w_stat.idle;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTH
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !w_stat.idle)
        else $error("core stayed idle after an accepted word");

    a_take_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_m_axis_tvalid)
        else $error("result handed over but output word not valid");

    a_idle_done_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_stat.idle, w_stat.done}))
        else $error("core reports idle and done together");

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.done && o_m_axis_tvalid && !i_m_axis_tready) |=> w_stat.done)
        else $error("core result dropped while output word stalled");
`endif

endmodule

FILE: bench/legendre_eval_checker.sv
`timescale 1ns / 100ps

module legendre_eval_checker import lpe_pkg::*; #(
    parameter int MAX_DEGREE = 50,
    parameter int FRAC_BITS  = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [DATA_W-1:0]   i_s_tdata,   // point
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [2*DATA_W-1:0] i_m_tdata,   // prior_poly_value high, poly_value low
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [DEG_W-1:0]    i_cfg_data,  // degree
    input  logic                i_end,
    output int                  o_failures,
    output int                  o_pending
);

    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    logic [DEG_W-1:0] degree_reg = DEG_W'(1);
    t_lpe_res         expected_q[$];
    int               errors = 0;
    bit               end_seen = 1'b0;

    assign o_failures = errors;

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Runs the three-term recurrence with the block's rounding and its
    // reciprocal-multiply division, step by step up to the clamped degree.
    function automatic t_lpe_res legendre_at(input logic [DATA_W-1:0] raw,
                                             input logic [DEG_W-1:0] deg);
        longint      one;
        longint      x;
        longint      prev;
        longint      cur;
        longint      m;
        longint      t;
        longint      nxt;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] q;
        int          n;
        bit          neg;
        t_lpe_res    res;
        one = longint'(1) << FRAC_BITS;
        x = longint'($signed(raw));
        n = int'(deg);
        if (n > MAX_DEGREE) n = MAX_DEGREE;
        if (x > one) x = one;
        if (x < -one) x = -one;
        if (n == 0) begin
            prev = 0;
            cur = one;
        end else begin
            prev = one;
            cur = x;
            for (int k = 2; k <= n; k++) begin
                neg = (x < 0) != (cur < 0);
                p = (abs64(x) * abs64(cur) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                m = neg ? -longint'(p) : longint'(p);
                t = longint'(2 * k - 1) * m - longint'(k - 1) * prev;
                r = ((64'd1 << 32) + 64'(k / 2)) / 64'(k);
                u = abs64(t);
                q = (u >> 32) * r + (((u & 64'hFFFF_FFFF) * r + 64'h8000_0000) >> 32);
                nxt = (t < 0) ? -longint'(q) : longint'(q);
                if (nxt > Q_MAX) nxt = Q_MAX;
                else if (nxt < Q_MIN) nxt = Q_MIN;
                prev = cur;
                cur = nxt;
            end
        end
        res.poly_value = cur[DATA_W-1:0];
        res.prior_poly_value = prev[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lpe_res got;
        t_lpe_res want;
        if (!i_rst_n) begin
            degree_reg = DEG_W'(1);
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) degree_reg = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(legendre_at(i_s_tdata, degree_reg));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_q.size() == 0) begin
                    $error("result word %h arrived with nothing expected", i_m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.poly_value !== want.poly_value) begin
                        $error("poly_value: expected %0d, actual %0d",
                               want.poly_value, got.poly_value);
                        errors++;
                    end
                    if (got.prior_poly_value !== want.prior_poly_value) begin
                        $error("prior_poly_value: expected %0d, actual %0d",
                               want.prior_poly_value, got.prior_poly_value);
                        errors++;
                    end
                end
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (expected_q.size() != 0) begin
                    $error("%0d result words never arrived", expected_q.size());
                    errors += expected_q.size();
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

FILE: bench/tb_legendre_polynomial_eval.sv
`timescale 1ns / 100ps

module tb_legendre_polynomial_eval import lpe_pkg::*;;

    localparam int MAX_DEGREE = 50;
    localparam int FRAC_BITS  = 30;
    localparam int PHASES     = 16;
    localparam int PHASE_LEN  = 125;
    localparam int QUIET_FROM = 14;
    localparam int SQUEEZE_AT = 4;
    localparam int HOLD_LEN   = 1500;
    localparam int DRAIN_WAIT = 400;
    localparam int LIMIT      = 4_000_000;
    localparam int DIR_N      = 22;

    localparam logic [DEG_W-1:0] DIR_DEG [DIR_N] = '{
        6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
        6'd0, 6'd0,
        6'd2, 6'd2, 6'd2,
        6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
        6'd63, 6'd63,
        6'd51,
        6'd3, 6'd3
    };
    localparam logic [DATA_W-1:0] DIR_PT [DIR_N] = '{
        32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h4000_0001,
        32'h2000_0000, 32'hFFFF_FFFF,
        32'h4000_0000, 32'hC000_0000, 32'h2000_0000,
        32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 32'h2000_0000, 32'h7FFF_FFFF,
        32'h8000_0000,
        32'h4000_0000, 32'hFFFF_CFC7,
        32'h1234_5678,
        32'hE000_0000, 32'h0000_0001
    };

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [DEG_W-1:0]    cfg_data = '0;
    logic                end_of_run = 1'b0;
    int                  failures;
    int                  pending;
    int                  cycles = 0;
    bit                  quiet = 1'b0;
    bit                  squeeze = 1'b0;
    logic [DEG_W-1:0]    cur_degree = 6'd1;

    always #4 i_clk = ~i_clk;

    legendre_polynomial_eval #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    legendre_eval_checker #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_end       (end_of_run),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls in short random bursts, and once for a long stretch
    // so that the block holds a finished word and refuses new points.
    initial begin : sink
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (squeeze && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_point(input logic [DATA_W-1:0] pt);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pt;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The degree is only changed with no word in flight.
    task automatic load_degree(input logic [DEG_W-1:0] deg);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= deg;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cur_degree = deg;
    endtask

    initial begin : stimulus
        logic [DEG_W-1:0]  deg;
        logic [DATA_W-1:0] pt;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_DEG[i] != cur_degree) load_degree(DIR_DEG[i]);
            send_point(DIR_PT[i]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       deg = 6'd0;
                1:       deg = 6'd50;
                2:       deg = 6'd63;
                3:       deg = 6'd1;
                default: deg = $urandom_range(0, 1) ? DEG_W'($urandom_range(0, 63))
                                                    : DEG_W'($urandom_range(2, 12));
            endcase
            load_degree(deg);
            if (ph == QUIET_FROM) quiet = 1'b1;
            if (ph == SQUEEZE_AT) squeeze = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: pt = $urandom();
                    2: pt = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
                    3: pt = $urandom_range(0, 1) ? 32'h4000_0000 - $urandom_range(0, 255)
                                                 : 32'hC000_0000 + $urandom_range(0, 255);
                    4: pt = $urandom_range(0, 255) - 128;
                    default: pt = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
                endcase
                send_point(pt);
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/lpe_pkg.sv
sv/lpe_mul.sv
sv/lpe_rrom.sv
sv/lpe_core.sv
sv/legendre_polynomial_eval.sv
bench/legendre_eval_checker.sv
bench/tb_legendre_polynomial_eval.sv
